// ----- rtl/lkv_pkg.sv -----
// lkv_pkg: shared types and constants of the lru key-value cache
`timescale 1ns / 1ps
`default_nettype none
package lkv_pkg;

   // request kinds carried on req_tuser
   localparam logic REQ_PUT = 1'b0;
   localparam logic REQ_GET = 1'b1;

   // read value returned on a miss
   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   // capacity register reset value and width
   localparam int           CAP_W     = 5;
   localparam logic [4:0]   CAP_RESET = 5'd16;

   // one stored entry, key in the lowest bits
   typedef struct packed {
      logic [63:0] stamp;
      logic [31:0] value;
      logic [31:0] key;
   } lkv_entry_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_UPDATE,
      ST_RESP
   } lkv_state_type;

   // control from the sequencer to the scan unit
   typedef struct packed {
      logic start;     // clear the match flag for a new transaction
      logic rd_valid;  // memory read data is valid this cycle
   } lkv_scan_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/lkv_ram.sv -----
// lkv_ram: generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lkv_ram #(
   parameter int WIDTH  = 128,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/lkv_scan.sv -----
// lkv_scan: key match and oldest-stamp search over streamed entries
`timescale 1ns / 1ps
`default_nettype none
module lkv_scan
   import lkv_pkg::*;
#(
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lkv_scan_ctrl_type ctrl,
   input  wire logic [ADDR_W-1:0] rd_idx,
   input  wire lkv_entry_type     rd_entry,
   input  wire logic [31:0]       req_key,
   output logic                   hit,
   output logic      [ADDR_W-1:0] hit_idx,
   output logic      [31:0]       hit_value,
   output logic      [ADDR_W-1:0] old_idx
);

   logic              hit_ff;
   logic [ADDR_W-1:0] hit_idx_ff;
   logic [31:0]       hit_value_ff;
   logic [63:0]       old_stamp_ff;
   logic [ADDR_W-1:0] old_idx_ff;
   logic              key_eq;
   logic              older;

   assign key_eq = (rd_entry.key == req_key);
   // slot zero seeds the search, later slots must be strictly older
   assign older  = (rd_idx == '0) || (rd_entry.stamp < old_stamp_ff);

   // match flag
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctrl.start) begin
         hit_ff <= 1'b0;
      end else if (ctrl.rd_valid && key_eq) begin
         hit_ff <= 1'b1;
      end
   end

   // match payload, first match kept
   always_ff @(posedge clock) begin
      if (ctrl.rd_valid && key_eq && !hit_ff) begin
         hit_idx_ff   <= rd_idx;
         hit_value_ff <= rd_entry.value;
      end
   end

   // oldest entry tracking
   always_ff @(posedge clock) begin
      if (ctrl.rd_valid && older) begin
         old_stamp_ff <= rd_entry.stamp;
         old_idx_ff   <= rd_idx;
      end
   end

   assign hit       = hit_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_value = hit_value_ff;
   assign old_idx   = old_idx_ff;

endmodule
`default_nettype wire

// ----- rtl/lru_key_value_cache_core.sv -----
// lru_key_value_cache_core: fully associative key-value cache with lru replacement
// Each transaction reads every filled slot from the entry memory, one slot a cycle
// through its single read port, then passes the finish and update states before the
// next one can be taken; an empty cache goes straight to update. A get result is
// registered in the update state, or later in the response state while the output
// is stalled, and then shows on rsp_tvalid. Synchronous active-high reset empties
// the cache, clears the tick counter and sets capacity to 16.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache_core
   import lkv_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data,   // capacity_in_use
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,     // key [31:0], put_value [63:32]
   input  wire logic        req_tuser,     // req_type
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,     // read_value [31:0]
   output logic             rsp_tuser      // found
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = (CW > CAP_W) ? CW : CAP_W;
   localparam int EW_SLOTS = SLOTS;

   lkv_state_type     state_ff, state_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [63:0]       tick_ff, tick_in;
   logic [AW-1:0]     scan_ff, scan_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [AW-1:0]     rd_idx_ff;
   logic              is_get_ff;
   logic [31:0]       key_ff;
   logic [31:0]       val_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [31:0]       rsp_data_ff;

   logic              accept;
   logic              out_free;
   logic              rsp_load;
   logic              last_read;
   logic              room;
   logic [EW-1:0]     eff_cap;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   lkv_entry_type     mem_wdata;
   logic              mem_re;
   lkv_entry_type     mem_rdata;
   lkv_scan_ctrl_type scan_ctrl;
   logic              hit;
   logic [AW-1:0]     hit_idx;
   logic [31:0]       hit_value;
   logic [AW-1:0]     old_idx;

   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign last_read = (CW'(scan_ff) == (fill_ff - 1'b1));

   // effective capacity: zero reads as one, clipped to the built depth
   always_comb begin
      priority if (cap_ff == '0) begin
         eff_cap = EW'(1);
      end else if (EW'(cap_ff) > EW'(EW_SLOTS)) begin
         eff_cap = EW'(EW_SLOTS);
      end else begin
         eff_cap = EW'(cap_ff);
      end
   end
   assign room = (EW'(fill_ff) < eff_cap);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (fill_ff == '0) ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_read) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = (is_get_ff == REQ_GET && !out_free) ? ST_RESP : ST_IDLE;
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready         = 1'b0;
      scan_in            = scan_ff;
      rd_pend_in         = 1'b0;
      mem_re             = 1'b0;
      mem_we             = 1'b0;
      mem_waddr          = hit_idx;
      mem_wdata.key      = key_ff;
      mem_wdata.value    = val_ff;
      mem_wdata.stamp    = tick_ff;
      fill_in            = fill_ff;
      tick_in            = tick_ff;
      rsp_load           = 1'b0;
      scan_ctrl.start    = 1'b0;
      scan_ctrl.rd_valid = rd_pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               tick_in         = tick_ff + 64'd1;
               scan_in         = '0;
               scan_ctrl.start = 1'b1;
            end
         end
         ST_SCAN: begin
            mem_re     = 1'b1;
            rd_pend_in = 1'b1;
            scan_in    = scan_ff + 1'b1;
         end
         ST_FINISH: begin
         end
         ST_UPDATE: begin
            if (is_get_ff == REQ_GET) begin
               // a hit restamps the entry, value unchanged
               mem_we          = hit;
               mem_wdata.value = hit_value;
               rsp_load        = out_free;
            end else if (hit) begin
               mem_we = 1'b1;
            end else if (room) begin
               mem_we    = 1'b1;
               mem_waddr = fill_ff[AW-1:0];
               fill_in   = fill_ff + 1'b1;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = old_idx;
            end
         end
         ST_RESP: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         fill_ff      <= '0;
         tick_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         tick_ff      <= tick_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // request capture and scan address
   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      rd_idx_ff <= scan_ff;
      if (accept) begin
         is_get_ff <= req_tuser;
         key_ff    <= req_tdata[31:0];
         val_ff    <= req_tdata[63:32];
      end
   end

   // response register
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= hit;
         rsp_data_ff  <= hit ? hit_value : MISS_VALUE;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_data_ff;

   // entry memory
   lkv_ram #(
      .WIDTH ($bits(lkv_entry_type)),
      .DEPTH (SLOTS),
      .ADDR_W(AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(scan_ff),
      .rd_data(mem_rdata)
   );

   // match and victim search
   lkv_scan #(
      .ADDR_W(AW)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (scan_ctrl),
      .rd_idx   (rd_idx_ff),
      .rd_entry (mem_rdata),
      .req_key  (key_ff),
      .hit      (hit),
      .hit_idx  (hit_idx),
      .hit_value(hit_value),
      .old_idx  (old_idx)
   );

endmodule
`default_nettype wire

// ----- rtl/lkv_checker.sv -----
// lkv_checker: port-level assertions for the lru key-value cache
`timescale 1ns / 1ps
`default_nettype none
module lkv_checker
   import lkv_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // no response right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // one transaction at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // a miss always carries minus one
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == MISS_VALUE)
      else $error("miss with wrong value");

   // a response never appears in the cycle right after acceptance
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response too early");

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
`default_nettype wire
